>>> hdl/kclc_pkg.sv
package kclc_pkg;

  // Field widths
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned DRIVE_W  = 4;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned EVENT_W  = 4;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CODE_LEN = 4;

  typedef logic [KEY_W-1:0] digit_t;
  typedef digit_t [CODE_LEN-1:0] code_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TICKS = 1'd1;

  // Configuration reset values
  localparam logic [TICK_W-1:0] ENTRY_TICKS_RST   = 8'd20;
  localparam logic [TICK_W-1:0] MESSAGE_TICKS_RST = 8'd6;

  // Code that the lock holds after reset (position 0 is the first digit)
  localparam code_t CODE_RST = {4'd4, 4'd3, 4'd2, 4'd1};

  // Key codes
  localparam digit_t KEY_DIGIT_MAX = 4'd9;
  localparam digit_t KEY_ERASE     = 4'hA;
  localparam digit_t KEY_CHANGE    = 4'hB;

  // Port drive bits
  localparam logic [DRIVE_W-1:0] DRV_NONE  = 4'h0;
  localparam logic [DRIVE_W-1:0] DRV_BUSY  = 4'h1;
  localparam logic [DRIVE_W-1:0] DRV_GREEN = 4'h2;
  localparam logic [DRIVE_W-1:0] DRV_RED   = 4'h4;
  localparam logic [DRIVE_W-1:0] DRV_MAG   = 4'h8;

  // Lock modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACCEPT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DENIED = 3'd5;

  // Event codes reported with each result
  localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
  localparam logic [EVENT_W-1:0] EV_DIGIT    = 4'd1;
  localparam logic [EVENT_W-1:0] EV_ERASED   = 4'd2;
  localparam logic [EVENT_W-1:0] EV_GRANTED  = 4'd3;
  localparam logic [EVENT_W-1:0] EV_DENIED   = 4'd4;
  localparam logic [EVENT_W-1:0] EV_CHANGE   = 4'd5;
  localparam logic [EVENT_W-1:0] EV_STORED   = 4'd6;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_IDLE     = 4'd8;

endpackage

>>> hdl/keypad_code_lock_controller.sv
// Four-digit keypad code lock controller.
// Requests arrive on the evt channel (evt_valid/evt_ready): action 0 is a
// half-second tick, action 1 is a decoded key press carried on key.
// Each request produces exactly one result on the res channel
// (res_valid/res_ready): port drive, lock mode, digits held, an event code
// and the echoed digit during code change.
// An accepted request's result is registered and shows in the cycle after
// acceptance. Throughput is one request per cycle while the receiver keeps
// up; the state update and the four-digit compare are done in one
// combinational pass ahead of the result register.
// If the receiver stalls, the result register holds its value and
// evt_ready drops only while that register is full and not being taken.
// The cfg channel writes entry_ticks (index 0) and message_ticks (index 1);
// it is always ready and is meant to be used while the lock is quiet.
// Reset returns the lock to idle with the code 1,2,3,4, entry_ticks 20 and
// message_ticks 6, and empties the result register.
module keypad_code_lock_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             evt_valid,
  output logic                             evt_ready,
  input  logic                             action,
  input  logic [kclc_pkg::KEY_W-1:0]       key,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [kclc_pkg::DRIVE_W-1:0]     drive,
  output logic [kclc_pkg::MODE_W-1:0]      mode,
  output logic [kclc_pkg::COUNT_W-1:0]     entered_count,
  output logic [kclc_pkg::EVENT_W-1:0]     event_res,
  output logic [kclc_pkg::KEY_W-1:0]       echo_digit,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kclc_pkg::TICK_W-1:0]      cfg_data
);
  import kclc_pkg::*;

  // Configuration and lock state
  logic [TICK_W-1:0]  entry_ticks;
  logic [TICK_W-1:0]  message_ticks;
  code_t              stored_code;
  code_t              entry_digits;
  logic [COUNT_W-1:0] digit_count;
  logic [MODE_W-1:0]  lock_mode;
  logic [TICK_W-1:0]  tick_countdown;
  logic [DRIVE_W-1:0] port_drive;

  // Next values
  code_t              stored_code_next;
  code_t              entry_digits_next;
  logic [COUNT_W-1:0] digit_count_next;
  logic [MODE_W-1:0]  lock_mode_next;
  logic [TICK_W-1:0]  tick_countdown_next;
  logic [DRIVE_W-1:0] port_drive_next;
  logic [EVENT_W-1:0] event_next;
  logic [KEY_W-1:0]   echo_next;

  // Working values
  logic [MODE_W-1:0]  cur_mode;
  logic [COUNT_W-1:0] cur_count;
  logic [TICK_W-1:0]  cur_countdown;
  logic [DRIVE_W-1:0] cur_drive;
  logic [TICK_W-1:0]  tick_dec;
  logic               evt_accept;

  assign evt_ready  = !res_valid || res_ready;
  assign evt_accept = evt_valid && evt_ready;
  assign cfg_ready  = 1'b1;

  // One event: state update and result in a single pass.
  always_comb begin
    // An unknown mode code falls back to idle.
    if (lock_mode > MODE_DENIED) begin
      cur_mode      = MODE_IDLE;
      cur_count     = '0;
      cur_countdown = '0;
      cur_drive     = DRV_NONE;
    end else begin
      cur_mode      = lock_mode;
      cur_count     = digit_count;
      cur_countdown = tick_countdown;
      cur_drive     = port_drive;
    end

    tick_dec            = cur_countdown - 8'd1;
    stored_code_next    = stored_code;
    entry_digits_next   = entry_digits;
    digit_count_next    = cur_count;
    lock_mode_next      = cur_mode;
    tick_countdown_next = cur_countdown;
    port_drive_next     = cur_drive;
    event_next          = EV_NONE;
    echo_next           = '0;

    if (!action) begin
      // Tick: count down and leave the current mode when the period ends.
      if (cur_mode != MODE_IDLE) begin
        tick_countdown_next = tick_dec;
        if (tick_dec == '0) begin
          event_next = (cur_mode == MODE_ENTRY || cur_mode == MODE_CHANGE) ?
                       EV_TIMEOUT : EV_IDLE;
          lock_mode_next      = MODE_IDLE;
          port_drive_next     = DRV_NONE;
          digit_count_next    = '0;
          tick_countdown_next = '0;
        end
      end
    end else begin
      unique case (cur_mode) inside
        MODE_IDLE: begin
          // A digit starts a new entry.
          if (key <= KEY_DIGIT_MAX) begin
            entry_digits_next[0] = key;
            digit_count_next     = 3'd1;
            port_drive_next      = DRV_BUSY;
            tick_countdown_next  = entry_ticks;
            lock_mode_next       = MODE_ENTRY;
            event_next           = EV_DIGIT;
          end
        end
        MODE_ENTRY, MODE_CHANGE: begin
          if (key <= KEY_DIGIT_MAX) begin
            entry_digits_next[cur_count[1:0]] = key;
            if (cur_mode == MODE_CHANGE) begin
              if (cur_count == '0) begin
                port_drive_next = DRV_BUSY;
              end
              echo_next = key;
            end
            digit_count_next = cur_count + 3'd1;
            event_next       = EV_DIGIT;
            // The fourth digit completes the entry.
            if (cur_count == 3'd3) begin
              digit_count_next    = '0;
              tick_countdown_next = message_ticks;
              if (cur_mode == MODE_CHANGE) begin
                stored_code_next = entry_digits_next;
                lock_mode_next   = MODE_ACCEPT;
                port_drive_next  = DRV_GREEN;
                event_next       = EV_STORED;
              end else if (entry_digits_next == stored_code) begin
                lock_mode_next  = MODE_OPEN;
                port_drive_next = DRV_GREEN | DRV_MAG;
                event_next      = EV_GRANTED;
              end else begin
                lock_mode_next  = MODE_DENIED;
                port_drive_next = DRV_RED;
                event_next      = EV_DENIED;
              end
            end
          end else if (key == KEY_ERASE && cur_count != '0) begin
            digit_count_next = cur_count - 3'd1;
            event_next       = EV_ERASED;
          end
        end
        MODE_OPEN: begin
          // The change key starts entry of a new code.
          if (key == KEY_CHANGE) begin
            lock_mode_next      = MODE_CHANGE;
            port_drive_next     = DRV_GREEN;
            digit_count_next    = '0;
            tick_countdown_next = entry_ticks;
            event_next          = EV_CHANGE;
          end
        end
        default: begin
          // Keys are ignored in the accepted and denied modes.
        end
      endcase
    end
  end

  // Control state, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ticks    <= ENTRY_TICKS_RST;
      message_ticks  <= MESSAGE_TICKS_RST;
      stored_code    <= CODE_RST;
      digit_count    <= '0;
      lock_mode      <= MODE_IDLE;
      tick_countdown <= '0;
      port_drive     <= DRV_NONE;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENTRY_TICKS) begin
          entry_ticks <= cfg_data;
        end else begin
          message_ticks <= cfg_data;
        end
      end
      if (evt_accept) begin
        stored_code    <= stored_code_next;
        digit_count    <= digit_count_next;
        lock_mode      <= lock_mode_next;
        tick_countdown <= tick_countdown_next;
        port_drive     <= port_drive_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Entry buffer and result payload need no reset.
  always_ff @(posedge clk) begin
    if (evt_accept) begin
      entry_digits  <= entry_digits_next;
      drive         <= port_drive_next;
      mode          <= lock_mode_next;
      entered_count <= digit_count_next;
      event_res     <= event_next;
      echo_digit    <= echo_next;
    end
  end

endmodule

>>> verif/keypad_code_lock_controller_tb.sv
`timescale 1ns / 100ps

module testbench;
  import kclc_pkg::*;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;
  localparam digit_t KEY_UNUSED_LO = 4'hC;
  localparam digit_t KEY_UNUSED_HI = 4'hF;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned ITEMS_TOTAL   = 800;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_GUARD  = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One lock result as seen on the result channel.
  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [EVENT_W-1:0] ev;
    digit_t             echo;
  } lock_result_t;

  // Tracks the lock state and holds the results still owed by the block.
  class lock_tracker;
    logic [TICK_W-1:0]  entry_ticks;
    logic [TICK_W-1:0]  message_ticks;
    code_t              stored_code;
    code_t              entry_digits;
    logic [COUNT_W-1:0] digit_count;
    logic [MODE_W-1:0]  lock_mode;
    logic [TICK_W-1:0]  countdown;
    logic [DRIVE_W-1:0] port_drive;
    lock_result_t       owed_results[$];
    int unsigned        mismatches;
    int unsigned        noted_requests;

    function new();
      entry_ticks = ENTRY_TICKS_RST;
      message_ticks = MESSAGE_TICKS_RST;
      stored_code = CODE_RST;
      entry_digits = '0;
      mismatches = 0;
      noted_requests = 0;
      go_idle();
    endfunction

    function void go_idle();
      lock_mode = MODE_IDLE;
      port_drive = DRV_NONE;
      digit_count = '0;
      countdown = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      case (idx)
        CFG_ENTRY_TICKS: entry_ticks = data;
        CFG_MESSAGE_TICKS: message_ticks = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Advance the lock by one accepted request and note the result it owes.
    function void note_request(logic act, digit_t k);
      lock_result_t r;
      logic [EVENT_W-1:0] ev;
      digit_t echo;
      ev = EV_NONE;
      echo = '0;
      if (lock_mode > MODE_DENIED) go_idle();
      if (act == ACT_TICK) begin
        if (lock_mode != MODE_IDLE) begin
          countdown = countdown - 1'b1;
          if (countdown == '0) begin
            ev = (lock_mode == MODE_ENTRY || lock_mode == MODE_CHANGE) ? EV_TIMEOUT : EV_IDLE;
            go_idle();
          end
        end
      end else if (lock_mode == MODE_IDLE) begin
        if (k <= KEY_DIGIT_MAX) begin
          entry_digits[0] = k;
          digit_count = 3'd1;
          port_drive = DRV_BUSY;
          countdown = entry_ticks;
          lock_mode = MODE_ENTRY;
          ev = EV_DIGIT;
        end
      end else if (lock_mode == MODE_ENTRY || lock_mode == MODE_CHANGE) begin
        if (k <= KEY_DIGIT_MAX) begin
          entry_digits[digit_count[1:0]] = k;
          if (lock_mode == MODE_CHANGE) begin
            if (digit_count == '0) port_drive = DRV_BUSY;
            echo = k;
          end
          digit_count = digit_count + 1'b1;
          ev = EV_DIGIT;
          if (digit_count >= CODE_LEN) begin
            digit_count = '0;
            countdown = message_ticks;
            if (lock_mode == MODE_CHANGE) begin
              stored_code = entry_digits;
              lock_mode = MODE_ACCEPT;
              port_drive = DRV_GREEN;
              ev = EV_STORED;
            end else if (stored_code == entry_digits) begin
              lock_mode = MODE_OPEN;
              port_drive = DRV_GREEN | DRV_MAG;
              ev = EV_GRANTED;
            end else begin
              lock_mode = MODE_DENIED;
              port_drive = DRV_RED;
              ev = EV_DENIED;
            end
          end
        end else if (k == KEY_ERASE && digit_count > '0) begin
          digit_count = digit_count - 1'b1;
          ev = EV_ERASED;
        end
      end else if (lock_mode == MODE_OPEN) begin
        if (k == KEY_CHANGE) begin
          lock_mode = MODE_CHANGE;
          port_drive = DRV_GREEN;
          digit_count = '0;
          countdown = entry_ticks;
          ev = EV_CHANGE;
        end
      end
      noted_requests++;
      r.drive = port_drive;
      r.mode = lock_mode;
      r.count = digit_count;
      r.ev = ev;
      r.echo = echo;
      owed_results.push_back(r);
    endfunction

    // Compare one result from the block with the oldest owed result.
    function void check_result(logic [DRIVE_W-1:0] drv, logic [MODE_W-1:0] md,
                               logic [COUNT_W-1:0] cnt, logic [EVENT_W-1:0] ev,
                               digit_t echo);
      lock_result_t r;
      if (owed_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      r = owed_results.pop_front();
      if (drv !== r.drive) begin
        $error("drive: expected %0d, actual %0d", r.drive, drv);
        mismatches++;
      end
      if (md !== r.mode) begin
        $error("mode: expected %0d, actual %0d", r.mode, md);
        mismatches++;
      end
      if (cnt !== r.count) begin
        $error("entered_count: expected %0d, actual %0d", r.count, cnt);
        mismatches++;
      end
      if (ev !== r.ev) begin
        $error("event_res: expected %0d, actual %0d", r.ev, ev);
        mismatches++;
      end
      if (echo !== r.echo) begin
        $error("echo_digit: expected %0d, actual %0d", r.echo, echo);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_ready;
  logic                 action = ACT_TICK;
  digit_t               key = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic [DRIVE_W-1:0]   drive;
  logic [MODE_W-1:0]    mode;
  logic [COUNT_W-1:0]   entered_count;
  logic [EVENT_W-1:0]   event_res;
  digit_t               echo_digit;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  lock_tracker sb;
  int unsigned burst_left = 0;
  bit          evt_offered = 1'b0;
  int unsigned hold_off_request = 0;

  keypad_code_lock_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (evt_valid),
    .evt_ready     (evt_ready),
    .action        (action),
    .key           (key),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .drive         (drive),
    .mode          (mode),
    .entered_count (entered_count),
    .event_res     (event_res),
    .echo_digit    (echo_digit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result(drive, mode, entered_count, event_res, echo_digit);
  end

  // Result-side stalls: a changing style, plus one long hold-off on request.
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  int unsigned style = 0;
  int unsigned style_left = 0;
  logic [3:0]  rx_phase = '0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_seen != hold_off_request) begin
      hold_seen = hold_off_request;
      hold_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      case (style)
        0: res_ready <= 1'b1;
        1: res_ready <= 1'($urandom_range(0, 1));
        2: res_ready <= ($urandom_range(0, 3) == 0);
        default: res_ready <= rx_phase[2];
      endcase
    end
  end

  // Offer one request and hold it until taken; bursts end with a random gap.
  task automatic send_request(input logic act, input digit_t k);
    evt_valid <= 1'b1;
    action <= act;
    key <= k;
    evt_offered = 1'b1;
    do @(posedge clk); while (!evt_ready);
    sb.note_request(act, k);
    if (burst_left == 0) begin
      evt_valid <= 1'b0;
      evt_offered = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, digit_t'($urandom_range(0, 15)));
  endtask

  // Stop offering and wait for every owed result.
  task automatic drain();
    if (evt_offered) begin
      evt_valid <= 1'b0;
      evt_offered = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both tick registers back to back while the lock is quiet.
  task automatic write_config(input logic [TICK_W-1:0] entry_val,
                              input logic [TICK_W-1:0] msg_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ENTRY_TICKS;
    cfg_data <= entry_val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_ENTRY_TICKS, entry_val);
    cfg_index <= CFG_MESSAGE_TICKS;
    cfg_data <= msg_val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_MESSAGE_TICKS, msg_val);
    cfg_valid <= 1'b0;
  endtask

  // Key in four digits, now and then slipping in a wrong digit and erasing it.
  task automatic enter_code(input code_t c, input int unsigned erase_pct);
    for (int i = 0; i < CODE_LEN; i++) begin
      if ($urandom_range(0, 99) < erase_pct) begin
        send_request(ACT_KEY, digit_t'($urandom_range(0, 9)));
        send_request(ACT_KEY, KEY_ERASE);
      end
      if ($urandom_range(0, 15) == 0) send_tick();
      send_request(ACT_KEY, c[i]);
    end
  endtask

  // One random scenario, started from idle.
  task automatic random_scenario();
    code_t rc;
    int unsigned guard;
    int unsigned pick;
    guard = 0;
    while (sb.lock_mode != MODE_IDLE && guard < SETTLE_GUARD) begin
      send_tick();
      guard++;
    end
    for (int i = 0; i < CODE_LEN; i++) rc[i] = digit_t'($urandom_range(0, 9));
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 8: begin
        enter_code(sb.stored_code, pick == 8 ? 60 : 10);
        if (sb.lock_mode == MODE_OPEN && $urandom_range(0, 2) != 0) begin
          if ($urandom_range(0, 3) == 0)
            send_request(ACT_KEY, digit_t'($urandom_range(0, 15)));
          send_request(ACT_KEY, KEY_CHANGE);
          enter_code(rc, 20);
        end
      end
      4, 5: enter_code(rc, 10);
      6: begin
        // Partial entry; the next scenario's settling runs it into a timeout.
        repeat ($urandom_range(1, 3)) send_request(ACT_KEY, digit_t'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 0) send_request(ACT_KEY, KEY_ERASE);
      end
      default: begin
        repeat ($urandom_range(1, 6))
          send_request(logic'($urandom_range(0, 1)), digit_t'($urandom_range(0, 15)));
      end
    endcase
  endtask

  initial begin
    int unsigned target;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset settings.
    send_request(ACT_TICK, KEY_UNUSED_HI);
    send_request(ACT_KEY, KEY_UNUSED_LO);
    send_request(ACT_KEY, KEY_UNUSED_HI);
    send_request(ACT_KEY, KEY_ERASE);
    send_request(ACT_KEY, KEY_CHANGE);
    enter_code(CODE_RST, 0);
    send_request(ACT_KEY, KEY_ERASE);
    send_request(ACT_KEY, KEY_CHANGE);
    send_request(ACT_KEY, 4'd0);
    send_request(ACT_KEY, KEY_ERASE);
    // Erase with nothing left in the buffer.
    send_request(ACT_KEY, KEY_ERASE);
    send_request(ACT_KEY, 4'd9);
    send_request(ACT_KEY, 4'd0);
    send_request(ACT_KEY, 4'd5);
    send_request(ACT_KEY, 4'd9);
    // Keys are ignored while the new code is being acknowledged.
    send_request(ACT_KEY, 4'd2);
    repeat (6) send_tick();

    // Random phases, each with its own tick settings, sharing one request budget.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: write_config(8'd1, 8'd1);
          2: write_config(8'd255, 8'd255);
          3: write_config(8'd0, 8'd0);
          4: write_config(8'd5, 8'd3);
          5: write_config(8'd2, 8'd255);
          6: write_config(8'd255, 8'd1);
          default: write_config(TICK_W'($urandom_range(1, 40)), TICK_W'($urandom_range(1, 12)));
        endcase
      end
      // Long result stall while requests keep coming.
      if (p == 4) hold_off_request++;
      target = ITEMS_TOTAL * (p + 1) / NUM_PHASES;
      do random_scenario(); while (sb.noted_requests < target);
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Run limit.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
hdl/kclc_pkg.sv
hdl/keypad_code_lock_controller.sv
verif/keypad_code_lock_controller_tb.sv
